// ===== sv/pehq_pkg.sv =====
// ============================================================================
// pehq_pkg
// shared types, codes and the key compare for the event heap queue
// ============================================================================
package pehq_pkg;

    localparam int QUEUE_DEPTH_DEF = 64;

    // payload word: {y, x, left edge, right edge, left param, right param}
    localparam int PAY_W = 128;
    localparam int KEY_W = 64;

    typedef enum logic [1:0] {
        FUNC_INSERT  = 2'd0,
        FUNC_PEEK    = 2'd1,
        FUNC_EXTRACT = 2'd2,
        FUNC_REMOVE  = 2'd3
    } func_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TOP_ORD,
        ST_RD_PAY,
        ST_RM_POS,
        ST_RM_MOVE,
        ST_RM_FILL_CHK,
        ST_RM_FILL_ORD,
        ST_RM_FILL_KEY,
        ST_UP_ORD,
        ST_UP_PAY,
        ST_UP_CMP,
        ST_PLACE,
        ST_DN_CHK,
        ST_DN_ORD1,
        ST_DN_PAY1,
        ST_DN_PAY2
    } state_t;

    // strict (y, x) signed order: a before b
    function automatic logic key_less(input logic [KEY_W-1:0] a, input logic [KEY_W-1:0] b);
        logic signed [31:0] ay;
        logic signed [31:0] ax;
        logic signed [31:0] by;
        logic signed [31:0] bx;
        ay = a[63:32];
        ax = a[31:0];
        by = b[63:32];
        bx = b[31:0];
        return (ay < by) || ((ay == by) && (ax < bx));
    endfunction

endpackage

// ===== sv/pehq_ram.sv =====
// ============================================================================
// pehq_ram
// simple dual-port memory, one write and one registered read per cycle
// ============================================================================
module pehq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/point_event_heap_queue.sv =====
// ============================================================================
// point_event_heap_queue
// indexed binary min-heap of events kept in three registered-read memories
// ============================================================================
// latency from accept to the result edge grows with each level climbed or sifted
// down: peek reads the order and payload memories; insert climbs from the new leaf;
// extract or remove frees the slot, fills the hole and then climbs or sifts down;
// all set by the one read port of each memory and its registered read
// throughput: one item at a time, busy high from accept through the result cycle
// reset clears occupancy and control only; results cannot be stalled
module point_event_heap_queue #(
    parameter int QUEUE_DEPTH = pehq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    output logic               done,
    input  logic [1:0]         func,
    input  logic signed [31:0] key_y,
    input  logic signed [31:0] key_x,
    input  logic [15:0]        left_edge,
    input  logic [15:0]        right_edge,
    input  logic [15:0]        param_left,
    input  logic [15:0]        param_right,
    input  logic [5:0]         slot,
    output logic               ok,
    output logic [5:0]         out_slot,
    output logic signed [31:0] out_y,
    output logic signed [31:0] out_x,
    output logic [15:0]        out_left_edge,
    output logic [15:0]        out_right_edge,
    output logic [15:0]        out_param_left,
    output logic [15:0]        out_param_right,
    output logic               moved,
    output logic [5:0]         moved_from,
    output logic [6:0]         count
);

    // index, count and child-index widths
    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int XW = AW + 2;
    localparam int PW = pehq_pkg::PAY_W;
    localparam int KW = pehq_pkg::KEY_W;

    pehq_pkg::state_t state_reg, state_next;
    pehq_pkg::func_t  func_reg, func_next;

    logic [CW-1:0] occ_reg, occ_next;
    logic [AW-1:0] cur_reg, cur_next;       // current hole in the heap
    logic [AW-1:0] elem_reg, elem_next;     // slot being sifted
    logic [AW-1:0] slot_reg, slot_next;     // slot reported or removed
    logic [AW-1:0] hole_reg, hole_next;
    logic [AW-1:0] n1_reg, n1_next;
    logic [AW-1:0] n2_reg, n2_next;
    logic [KW-1:0] k_reg, k_next;           // key of the sifted slot
    logic [KW-1:0] k1_reg, k1_next;         // key of the left child
    logic          climbed_reg, climbed_next;

    logic          ok_reg, ok_next;
    logic [AW-1:0] oslot_reg, oslot_next;
    logic [PW-1:0] opay_reg, opay_next;
    logic          moved_reg, moved_next;
    logic [AW-1:0] mfrom_reg, mfrom_next;

    // done strobe: the cycle after any path back to idle
    logic          done_reg, done_next;

    // memory ports
    logic          pay_we, ord_we, pos_we;
    logic [AW-1:0] pay_waddr, ord_waddr, pos_waddr;
    logic [PW-1:0] pay_wdata;
    logic [AW-1:0] ord_wdata, pos_wdata;
    logic [AW-1:0] pay_raddr, ord_raddr, pos_raddr;
    logic [PW-1:0] pay_rdata;
    logic [AW-1:0] ord_rdata, pos_rdata;

    // payload of the event in storage, by slot
    pehq_ram #(.WIDTH(PW), .DEPTH(QUEUE_DEPTH), .AW(AW)) u_pay (
        .clk   (clk),
        .we    (pay_we),
        .waddr (pay_waddr),
        .wdata (pay_wdata),
        .raddr (pay_raddr),
        .rdata (pay_rdata)
    );

    // heap index to slot
    pehq_ram #(.WIDTH(AW), .DEPTH(QUEUE_DEPTH), .AW(AW)) u_ord (
        .clk   (clk),
        .we    (ord_we),
        .waddr (ord_waddr),
        .wdata (ord_wdata),
        .raddr (ord_raddr),
        .rdata (ord_rdata)
    );

    // slot to heap index
    pehq_ram #(.WIDTH(AW), .DEPTH(QUEUE_DEPTH), .AW(AW)) u_pos (
        .clk   (clk),
        .we    (pos_we),
        .waddr (pos_waddr),
        .wdata (pos_wdata),
        .raddr (pos_raddr),
        .rdata (pos_rdata)
    );

    // ------------------------------------------------------------------
    // derived values
    // ------------------------------------------------------------------
    logic          accept;
    logic          full, empty, slot_ok, go_down;
    logic [AW-1:0] half, last_idx;
    logic [XW-1:0] c1, c2, occ_x;
    logic          c1_in, c2_in;
    logic [KW-1:0] pay_key;
    logic          up_less, dn1_less, l1, l12, l2, take1, take2;

    always_comb
    begin
        // an item is taken only while not busy
        accept   = start && !busy;
        full     = (occ_reg == CW'(QUEUE_DEPTH));
        empty    = (occ_reg == '0);
        slot_ok  = (32'(slot) < 32'(occ_reg));
        // insert never sifts down; removal sifts down if it could not climb
        go_down  = (func_reg != pehq_pkg::FUNC_INSERT) && !climbed_reg;
        half     = AW'((cur_reg - AW'(1)) >> 1);
        last_idx = AW'(occ_reg - CW'(1));
        c1       = {1'b0, cur_reg, 1'b1};
        c2       = c1 + XW'(1);
        occ_x    = XW'(occ_reg);
        c1_in    = (c1 < occ_x);
        c2_in    = (c2 < occ_x);
        pay_key  = pay_rdata[PW-1 -: KW];
        up_less  = pehq_pkg::key_less(k_reg, pay_key);
        dn1_less = pehq_pkg::key_less(pay_key, k_reg);
        l1       = pehq_pkg::key_less(k1_reg, k_reg);
        l12      = pehq_pkg::key_less(k1_reg, pay_key);
        l2       = pehq_pkg::key_less(pay_key, k_reg);
        // equal siblings pick the right child
        take1    = l1 && l12;
        take2    = (l1 && !l12) || (!l1 && l2);
    end

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pehq_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (pehq_pkg::func_t'(func))
                        pehq_pkg::FUNC_INSERT:
                            state_next = full ? pehq_pkg::ST_IDLE : pehq_pkg::ST_UP_ORD;
                        pehq_pkg::FUNC_PEEK, pehq_pkg::FUNC_EXTRACT:
                            state_next = empty ? pehq_pkg::ST_IDLE : pehq_pkg::ST_TOP_ORD;
                        default:
                            state_next = slot_ok ? pehq_pkg::ST_RD_PAY : pehq_pkg::ST_IDLE;
                    endcase
                end
            end
            pehq_pkg::ST_TOP_ORD:
                state_next = pehq_pkg::ST_RD_PAY;
            pehq_pkg::ST_RD_PAY:
            begin
                if (func_reg == pehq_pkg::FUNC_PEEK || occ_reg <= CW'(1))
                    state_next = pehq_pkg::ST_IDLE;
                else
                    state_next = pehq_pkg::ST_RM_POS;
            end
            pehq_pkg::ST_RM_POS:
                state_next = (last_idx != slot_reg) ? pehq_pkg::ST_RM_MOVE
                                                    : pehq_pkg::ST_RM_FILL_CHK;
            pehq_pkg::ST_RM_MOVE:
                state_next = pehq_pkg::ST_RM_FILL_CHK;
            pehq_pkg::ST_RM_FILL_CHK:
                state_next = (occ_reg == CW'(hole_reg)) ? pehq_pkg::ST_IDLE
                                                        : pehq_pkg::ST_RM_FILL_ORD;
            pehq_pkg::ST_RM_FILL_ORD:
                state_next = pehq_pkg::ST_RM_FILL_KEY;
            pehq_pkg::ST_RM_FILL_KEY:
                state_next = pehq_pkg::ST_UP_ORD;
            pehq_pkg::ST_UP_ORD:
            begin
                if (cur_reg != '0)
                    state_next = pehq_pkg::ST_UP_PAY;
                else
                    state_next = go_down ? pehq_pkg::ST_DN_CHK : pehq_pkg::ST_PLACE;
            end
            pehq_pkg::ST_UP_PAY:
                state_next = pehq_pkg::ST_UP_CMP;
            pehq_pkg::ST_UP_CMP:
            begin
                if (up_less)
                    state_next = pehq_pkg::ST_UP_ORD;
                else
                    state_next = go_down ? pehq_pkg::ST_DN_CHK : pehq_pkg::ST_PLACE;
            end
            pehq_pkg::ST_PLACE:
                state_next = pehq_pkg::ST_IDLE;
            pehq_pkg::ST_DN_CHK:
                state_next = c1_in ? pehq_pkg::ST_DN_ORD1 : pehq_pkg::ST_PLACE;
            pehq_pkg::ST_DN_ORD1:
                state_next = pehq_pkg::ST_DN_PAY1;
            pehq_pkg::ST_DN_PAY1:
                state_next = c2_in ? pehq_pkg::ST_DN_PAY2 : pehq_pkg::ST_PLACE;
            pehq_pkg::ST_DN_PAY2:
                state_next = (take1 || take2) ? pehq_pkg::ST_DN_CHK : pehq_pkg::ST_PLACE;
            default:
                state_next = pehq_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        done_next = (state_reg != pehq_pkg::ST_IDLE || accept)
                    && (state_next == pehq_pkg::ST_IDLE);
    end

    // ------------------------------------------------------------------
    // datapath and memory control
    // ------------------------------------------------------------------
    always_comb
    begin
        func_next    = func_reg;
        occ_next     = occ_reg;
        cur_next     = cur_reg;
        elem_next    = elem_reg;
        slot_next    = slot_reg;
        hole_next    = hole_reg;
        n1_next      = n1_reg;
        n2_next      = n2_reg;
        k_next       = k_reg;
        k1_next      = k1_reg;
        climbed_next = climbed_reg;
        ok_next      = ok_reg;
        oslot_next   = oslot_reg;
        opay_next    = opay_reg;
        moved_next   = moved_reg;
        mfrom_next   = mfrom_reg;

        pay_we    = 1'b0;
        pay_waddr = '0;
        pay_wdata = '0;
        pay_raddr = '0;
        ord_we    = 1'b0;
        ord_waddr = '0;
        ord_wdata = '0;
        ord_raddr = '0;
        pos_we    = 1'b0;
        pos_waddr = '0;
        pos_wdata = '0;
        pos_raddr = '0;

        case (state_reg)
            pehq_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    func_next    = pehq_pkg::func_t'(func);
                    climbed_next = 1'b0;
                    ok_next      = 1'b0;
                    oslot_next   = '0;
                    opay_next    = '0;
                    moved_next   = 1'b0;
                    mfrom_next   = '0;
                    case (pehq_pkg::func_t'(func))
                        pehq_pkg::FUNC_INSERT:
                        begin
                            if (!full)
                            begin
                                pay_we     = 1'b1;
                                pay_waddr  = AW'(occ_reg);
                                pay_wdata  = {key_y, key_x, left_edge, right_edge,
                                              param_left, param_right};
                                cur_next   = AW'(occ_reg);
                                elem_next  = AW'(occ_reg);
                                k_next     = {key_y, key_x};
                                ok_next    = 1'b1;
                                oslot_next = AW'(occ_reg);
                                opay_next  = pay_wdata;
                                occ_next   = occ_reg + CW'(1);
                            end
                        end
                        pehq_pkg::FUNC_PEEK, pehq_pkg::FUNC_EXTRACT:
                        begin
                            ord_raddr = '0;
                        end
                        default:
                        begin
                            pay_raddr = AW'(slot);
                            slot_next = AW'(slot);
                        end
                    endcase
                end
            end
            pehq_pkg::ST_TOP_ORD:
            begin
                slot_next = ord_rdata;
                pay_raddr = ord_rdata;
            end
            pehq_pkg::ST_RD_PAY:
            begin
                ok_next    = 1'b1;
                oslot_next = slot_reg;
                opay_next  = pay_rdata;
                pos_raddr  = slot_reg;
                if (func_reg != pehq_pkg::FUNC_PEEK && occ_reg <= CW'(1))
                    occ_next = '0;
            end
            pehq_pkg::ST_RM_POS:
            begin
                hole_next = pos_rdata;
                occ_next  = occ_reg - CW'(1);
                pay_raddr = last_idx;
                pos_raddr = last_idx;
            end
            pehq_pkg::ST_RM_MOVE:
            begin
                // last slot moves into the freed slot
                pay_we     = 1'b1;
                pay_waddr  = slot_reg;
                pay_wdata  = pay_rdata;
                ord_we     = 1'b1;
                ord_waddr  = pos_rdata;
                ord_wdata  = slot_reg;
                pos_we     = 1'b1;
                pos_waddr  = slot_reg;
                pos_wdata  = pos_rdata;
                moved_next = 1'b1;
                mfrom_next = AW'(occ_reg);
            end
            pehq_pkg::ST_RM_FILL_CHK:
            begin
                ord_raddr = AW'(occ_reg);
            end
            pehq_pkg::ST_RM_FILL_ORD:
            begin
                elem_next = ord_rdata;
                pay_raddr = ord_rdata;
            end
            pehq_pkg::ST_RM_FILL_KEY:
            begin
                k_next   = pay_key;
                cur_next = hole_reg;
            end
            pehq_pkg::ST_UP_ORD:
            begin
                ord_raddr = half;
            end
            pehq_pkg::ST_UP_PAY:
            begin
                n1_next   = ord_rdata;
                pay_raddr = ord_rdata;
            end
            pehq_pkg::ST_UP_CMP:
            begin
                if (up_less)
                begin
                    ord_we       = 1'b1;
                    ord_waddr    = cur_reg;
                    ord_wdata    = n1_reg;
                    pos_we       = 1'b1;
                    pos_waddr    = n1_reg;
                    pos_wdata    = cur_reg;
                    cur_next     = half;
                    climbed_next = 1'b1;
                end
            end
            pehq_pkg::ST_PLACE:
            begin
                ord_we    = 1'b1;
                ord_waddr = cur_reg;
                ord_wdata = elem_reg;
                pos_we    = 1'b1;
                pos_waddr = elem_reg;
                pos_wdata = cur_reg;
            end
            pehq_pkg::ST_DN_CHK:
            begin
                ord_raddr = AW'(c1);
            end
            pehq_pkg::ST_DN_ORD1:
            begin
                n1_next   = ord_rdata;
                pay_raddr = ord_rdata;
                ord_raddr = AW'(c2);
            end
            pehq_pkg::ST_DN_PAY1:
            begin
                k1_next = pay_key;
                if (c2_in)
                begin
                    n2_next   = ord_rdata;
                    pay_raddr = ord_rdata;
                end
                else if (dn1_less)
                begin
                    // lone left child moves up
                    ord_we    = 1'b1;
                    ord_waddr = cur_reg;
                    ord_wdata = n1_reg;
                    pos_we    = 1'b1;
                    pos_waddr = n1_reg;
                    pos_wdata = cur_reg;
                    cur_next  = AW'(c1);
                end
            end
            pehq_pkg::ST_DN_PAY2:
            begin
                if (take1)
                begin
                    ord_we    = 1'b1;
                    ord_waddr = cur_reg;
                    ord_wdata = n1_reg;
                    pos_we    = 1'b1;
                    pos_waddr = n1_reg;
                    pos_wdata = cur_reg;
                    cur_next  = AW'(c1);
                end
                else if (take2)
                begin
                    ord_we    = 1'b1;
                    ord_waddr = cur_reg;
                    ord_wdata = n2_reg;
                    pos_we    = 1'b1;
                    pos_waddr = n2_reg;
                    pos_wdata = cur_reg;
                    cur_next  = AW'(c2);
                end
            end
            default:
            begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= pehq_pkg::ST_IDLE;
            occ_reg     <= '0;
            done_reg    <= 1'b0;
            func_reg    <= pehq_pkg::FUNC_INSERT;
            climbed_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            occ_reg     <= occ_next;
            done_reg    <= done_next;
            func_reg    <= func_next;
            climbed_reg <= climbed_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        elem_reg  <= elem_next;
        slot_reg  <= slot_next;
        hole_reg  <= hole_next;
        n1_reg    <= n1_next;
        n2_reg    <= n2_next;
        k_reg     <= k_next;
        k1_reg    <= k1_next;
        ok_reg    <= ok_next;
        oslot_reg <= oslot_next;
        opay_reg  <= opay_next;
        moved_reg <= moved_next;
        mfrom_reg <= mfrom_next;
    end

    // ------------------------------------------------------------------
    // outputs
    // ------------------------------------------------------------------
    assign busy            = (state_reg != pehq_pkg::ST_IDLE) || done_reg;
    assign done            = done_reg;
    assign ok              = ok_reg;
    assign out_slot        = 6'(oslot_reg);
    assign out_y           = opay_reg[127:96];
    assign out_x           = opay_reg[95:64];
    assign out_left_edge   = opay_reg[63:48];
    assign out_right_edge  = opay_reg[47:32];
    assign out_param_left  = opay_reg[31:16];
    assign out_param_right = opay_reg[15:0];
    assign moved           = moved_reg;
    assign moved_from      = 6'(mfrom_reg);
    assign count           = 7'(occ_reg);

`ifndef ASSERT_OFF
    // occupancy never passes the depth
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CW'(QUEUE_DEPTH))
        else $error("occupancy above depth");

    // an accepted item makes the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    // result strobe lasts one cycle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

    // a failed command never reports a move
    a_fail_no_move: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !ok) |-> !moved)
        else $error("move reported on failure");
`endif

endmodule
